>>> rtl/tcw_pkg.sv
package tcw_pkg;

  // Request kinds on req_type
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_BACKGROUND = 1'b0;
  localparam logic CFG_FOREGROUND = 1'b1;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef enum logic [1:0] {
    OP_READ,
    OP_NEWLINE,
    OP_PUT,
    OP_TAB
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  ch;
    logic [10:0] addr;
    logic        in_range;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PUT,
    ST_SC_RD,
    ST_SC_WR,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

>>> rtl/tcw_front.sv
module tcw_front #(
  parameter int CELLS = 2000
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          hold,
  input  logic          push,
  output logic          full,
  input  logic          req_type,
  input  logic [7:0]    char_code,
  input  logic [10:0]   cell_address,
  output tcw_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);

  tcw_pkg::cmd_t entry [2];
  tcw_pkg::cmd_t incoming;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          accept;

  // Classify the request on entry
  always_comb begin
    incoming.ch       = char_code;
    incoming.addr     = cell_address;
    incoming.in_range = (32'(cell_address) < CELLS);
    if (req_type == tcw_pkg::REQ_READ) begin
      incoming.op = tcw_pkg::OP_READ;
    end else if (char_code == tcw_pkg::CH_NEWLINE) begin
      incoming.op = tcw_pkg::OP_NEWLINE;
    end else if (char_code == tcw_pkg::CH_TAB) begin
      incoming.op = tcw_pkg::OP_TAB;
    end else begin
      incoming.op = tcw_pkg::OP_PUT;
    end
  end

  assign full      = hold || (count == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop && cmd_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(accept) - 2'(cmd_pop && cmd_valid);
    end
  end

endmodule

>>> rtl/tcw_back.sv
module tcw_back #(
  parameter int COLS       = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  tcw_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  logic [7:0]    attr,
  input  logic          res_full,
  output logic          res_push,
  output tcw_pkg::res_t res,
  output logic          clearing
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int TW    = $clog2(TAB_SPACES + 1);

  localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST   = AW'(CELLS - COLS - 1);
  localparam logic [AW-1:0] COLS_A      = AW'(COLS);
  localparam logic [CW-1:0] LAST_COL    = CW'(COLS - 1);
  localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;

  logic [15:0]   screen [CELLS];
  logic [15:0]   rd_data;
  logic          we;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;
  logic [15:0]   wd;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] row_base;
  logic [AW-1:0] sp;
  logic [TW-1:0] reps;
  logic [7:0]    cur_ch;
  logic          cur_in_range;

  always_ff @(posedge clk) begin
    if (we) begin
      screen[wa] <= wd;
    end
    rd_data <= screen[ra];
  end

  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_CLEAR: begin
        if (sp == LAST_CELL) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (cmd_valid && !res_full) begin
          case (cmd.op)
            tcw_pkg::OP_READ:    state_next = tcw_pkg::ST_READ;
            tcw_pkg::OP_NEWLINE: begin
              state_next = (row == LAST_ROW) ? tcw_pkg::ST_SC_RD : tcw_pkg::ST_DONE;
            end
            default:             state_next = tcw_pkg::ST_PUT;
          endcase
        end
      end
      tcw_pkg::ST_READ: state_next = tcw_pkg::ST_IDLE;
      tcw_pkg::ST_PUT: begin
        if (col == LAST_COL && row == LAST_ROW) begin
          state_next = tcw_pkg::ST_SC_RD;
        end else if (reps > TW'(1)) begin
          state_next = tcw_pkg::ST_PUT;
        end else begin
          state_next = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_SC_RD: state_next = tcw_pkg::ST_SC_WR;
      tcw_pkg::ST_SC_WR: begin
        state_next = (sp == COPY_LAST) ? tcw_pkg::ST_FILL : tcw_pkg::ST_SC_RD;
      end
      tcw_pkg::ST_FILL: begin
        if (sp == LAST_CELL) begin
          state_next = (reps != '0) ? tcw_pkg::ST_PUT : tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_DONE: state_next = tcw_pkg::ST_IDLE;
      default:          state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we                = 1'b0;
    wa                = sp;
    wd                = 16'h0000;
    ra                = sp + COLS_A;
    cmd_pop           = 1'b0;
    res_push          = 1'b0;
    res.cell_value    = 16'h0000;
    res.cursor_column = 7'(col);
    res.cursor_row    = 5'(row);
    case (state)
      tcw_pkg::ST_CLEAR: we = 1'b1;
      tcw_pkg::ST_IDLE: begin
        cmd_pop = cmd_valid && !res_full;
        ra      = AW'(cmd.addr);
      end
      tcw_pkg::ST_READ: begin
        res_push       = 1'b1;
        res.cell_value = cur_in_range ? rd_data : 16'h0000;
      end
      tcw_pkg::ST_PUT: begin
        we = 1'b1;
        wa = row_base + AW'(col);
        wd = {attr, cur_ch};
      end
      tcw_pkg::ST_SC_RD: ra = sp + COLS_A;
      tcw_pkg::ST_SC_WR: begin
        we = 1'b1;
        wd = rd_data;
      end
      tcw_pkg::ST_FILL: begin
        we = 1'b1;
        wd = {attr, tcw_pkg::CH_SPACE};
      end
      tcw_pkg::ST_DONE: res_push = 1'b1;
      default: ;
    endcase
  end

  assign clearing = (state == tcw_pkg::ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tcw_pkg::ST_CLEAR;
      sp       <= '0;
      col      <= '0;
      row      <= '0;
      row_base <= '0;
      reps     <= '0;
    end else begin
      state <= state_next;
      case (state)
        tcw_pkg::ST_CLEAR: sp <= (sp == LAST_CELL) ? '0 : sp + AW'(1);
        tcw_pkg::ST_IDLE: begin
          if (cmd_pop) begin
            sp <= '0;
            case (cmd.op)
              tcw_pkg::OP_NEWLINE: begin
                reps <= '0;
                col  <= '0;
                // Bottom row stays put; the scroll makes room
                if (row != LAST_ROW) begin
                  row      <= row + RW'(1);
                  row_base <= row_base + COLS_A;
                end
              end
              tcw_pkg::OP_TAB: reps <= TW'(TAB_SPACES);
              default:         reps <= TW'(1);
            endcase
          end
        end
        tcw_pkg::ST_PUT: begin
          reps <= reps - TW'(1);
          if (col == LAST_COL) begin
            col <= '0;
            if (row != LAST_ROW) begin
              row      <= row + RW'(1);
              row_base <= row_base + COLS_A;
            end
          end else begin
            col <= col + CW'(1);
          end
        end
        tcw_pkg::ST_SC_WR: sp <= sp + AW'(1);
        tcw_pkg::ST_FILL:  sp <= (sp == LAST_CELL) ? '0 : sp + AW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_ch       <= (cmd.op == tcw_pkg::OP_TAB) ? tcw_pkg::CH_SPACE : cmd.ch;
      cur_in_range <= cmd.in_range;
    end
  end

`ifndef SYNTHESIS
  a_row_base: assert property (@(posedge clk) disable iff (rst)
    row_base == AW'(int'(row) * COLS))
    else $error("row base out of step with cursor row");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_CLEAR) |-> !cmd_pop)
    else $error("request taken during clearing pass");

  a_fill_bottom: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_FILL) |-> (sp > COPY_LAST))
    else $error("fill outside the bottom row");

  a_scroll_at_bottom: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::ST_SC_RD) |-> (row == LAST_ROW && col == '0))
    else $error("scroll with cursor off the bottom row start");
`endif

endmodule

>>> rtl/tcw_resq.sv
module tcw_resq (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_push,
  input  tcw_pkg::res_t res,
  output logic          res_full,
  input  logic          pop,
  output logic          empty,
  output tcw_pkg::res_t head
);

  tcw_pkg::res_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          take;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign take     = pop && !empty;
  assign head     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push && !res_full) begin
      entry[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push && !res_full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(res_push && !res_full) - 2'(take);
    end
  end

endmodule

>>> rtl/text_console_writer.sv
// Text console writer: a screen of COLS x ROWS 16-bit cells with a cursor.
// Request side is a queue: present req_type/char_code/cell_address with push;
// the request is taken when full is low. A write request stores char_code at
// the cursor (newline and tab handled as a console does); a read request
// returns cell cell_address on cell_value. Every request yields one result,
// shown while empty is low and taken with pop, carrying the cursor position.
// Colours are written on the cfg port (index 0 background, 1 foreground);
// cfg_ready is always high, and writes belong to idle periods.
// In the sequencer a character passes IDLE, PUT and DONE, a read IDLE and
// READ, a newline IDLE and DONE (a scroll between on the bottom row), a tab
// IDLE, PUT once per space and DONE; a two-entry request queue hides the
// hand-over. A scroll runs through the screen memory, a read state and a
// write state for each cell moved up, then a fill of the bottom row with
// spaces; meanwhile requests pile up and then full rises. After reset a
// clearing pass writes every cell to zero, one a cycle; full stays high
// meanwhile.
// A stalled receiver fills the two-entry result queue; the sequencer then
// waits, the request queue fills and full rises. No result is dropped.
module text_console_writer #(
  parameter int COLS       = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_address,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] cell_value,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  logic [3:0]    background_color;
  logic [3:0]    foreground_color;
  tcw_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;
  logic          clearing;
  logic          res_push;
  logic          res_full;
  tcw_pkg::res_t res;
  tcw_pkg::res_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      background_color <= 4'h0;
      foreground_color <= 4'hF;
    end else if (cfg_valid) begin
      case (cfg_index)
        tcw_pkg::CFG_BACKGROUND: background_color <= cfg_data;
        tcw_pkg::CFG_FOREGROUND: foreground_color <= cfg_data;
        default: ;
      endcase
    end
  end

  tcw_front #(
    .CELLS (COLS * ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .hold         (clearing),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .char_code    (char_code),
    .cell_address (cell_address),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop)
  );

  tcw_back #(
    .COLS       (COLS),
    .ROWS       (ROWS),
    .TAB_SPACES (TAB_SPACES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .attr      ({background_color, foreground_color}),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .clearing  (clearing)
  );

  tcw_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign cell_value    = head.cell_value;
  assign cursor_column = head.cursor_column;
  assign cursor_row    = head.cursor_row;

endmodule

>>> tb/sv/console_screen_check.sv
module console_screen_check #(
  parameter int COLS       = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        req_type,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_address,
  input  logic        empty,
  input  logic        pop,
  input  logic [15:0] cell_value,
  input  logic [6:0]  cursor_column,
  input  logic [4:0]  cursor_row,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  output int          mismatches,
  output int          pending_results
);

  localparam int CELLS = COLS * ROWS;

  logic [15:0]   screen_copy [CELLS];
  int            col_at;
  int            row_at;
  logic [3:0]    back_colour;
  logic [3:0]    fore_colour;
  tcw_pkg::res_t awaited_results [$];

  initial begin
    mismatches      = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [15:0] coloured(logic [7:0] ch);
    return {back_colour, fore_colour, ch};
  endfunction

  function automatic void wrap_and_scroll();
    if (col_at >= COLS) begin
      col_at = 0;
      row_at++;
    end
    if (row_at >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_copy[i] = screen_copy[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++)
        screen_copy[i] = coloured(tcw_pkg::CH_SPACE);
      col_at = 0;
      row_at = ROWS - 1;
    end
  endfunction

  function automatic void place_glyph(logic [7:0] ch);
    screen_copy[row_at * COLS + col_at] = coloured(ch);
    col_at++;
    wrap_and_scroll();
  endfunction

  function automatic tcw_pkg::res_t apply_request(logic kind, logic [7:0] ch,
                                                  logic [10:0] addr);
    tcw_pkg::res_t r;
    r.cell_value = '0;
    if (kind == tcw_pkg::REQ_READ) begin
      if (addr < CELLS) r.cell_value = screen_copy[addr];
    end else if (ch == tcw_pkg::CH_NEWLINE) begin
      col_at = 0;
      row_at++;
      wrap_and_scroll();
    end else if (ch == tcw_pkg::CH_TAB) begin
      for (int k = 0; k < TAB_SPACES; k++) place_glyph(tcw_pkg::CH_SPACE);
    end else begin
      place_glyph(ch);
    end
    r.cursor_column = 7'(col_at);
    r.cursor_row    = 5'(row_at);
    return r;
  endfunction

  always @(posedge clk) begin
    tcw_pkg::res_t want;
    if (rst) begin
      foreach (screen_copy[i]) screen_copy[i] = '0;
      col_at      = 0;
      row_at      = 0;
      back_colour = 4'h0;
      fore_colour = 4'hF;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tcw_pkg::CFG_BACKGROUND) back_colour = cfg_data;
        else fore_colour = cfg_data;
      end
      // compare before queuing, so a result never meets its own request
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result popped with no request outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (cell_value !== want.cell_value)
            report_mismatch($sformatf("cell_value %h, expected %h",
                                      cell_value, want.cell_value));
          if (cursor_column !== want.cursor_column)
            report_mismatch($sformatf("cursor_column %0d, expected %0d",
                                      cursor_column, want.cursor_column));
          if (cursor_row !== want.cursor_row)
            report_mismatch($sformatf("cursor_row %0d, expected %0d",
                                      cursor_row, want.cursor_row));
        end
      end
      if (push && !full)
        awaited_results.push_back(apply_request(req_type, char_code, cell_address));
    end
    pending_results <= awaited_results.size();
  end

endmodule

>>> tb/sv/text_console_writer_test.sv
module text_console_writer_test;

  localparam int COLS          = 80;
  localparam int ROWS          = 25;
  localparam int TAB_SPACES    = 4;
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_EVERY    = 350;
  localparam int SEGMENT_ITEMS = 235;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        req_type;
  logic [7:0]  char_code;
  logic [10:0] cell_address;
  logic        empty;
  logic        pop;
  logic [15:0] cell_value;
  logic [6:0]  cursor_column;
  logic [4:0]  cursor_row;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [3:0]  cfg_data;
  int          mismatches;
  int          pending_results;
  int          results_taken;

  text_console_writer #(
    .COLS(COLS), .ROWS(ROWS), .TAB_SPACES(TAB_SPACES)
  ) dut (.*);

  console_screen_check #(
    .COLS(COLS), .ROWS(ROWS), .TAB_SPACES(TAB_SPACES)
  ) screen_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic put_request(logic kind, logic [7:0] ch, logic [10:0] addr);
    push         <= 1'b1;
    req_type     <= kind;
    char_code    <= ch;
    cell_address <= addr;
    do @(posedge clk); while (full);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic set_colours(logic [3:0] back, logic [3:0] fore);
    cfg_valid <= 1'b1;
    cfg_index <= tcw_pkg::CFG_BACKGROUND;
    cfg_data  <= back;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= tcw_pkg::CFG_FOREGROUND;
    cfg_data  <= fore;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic stream_random(int count, bit steady);
    int          pick;
    logic [7:0]  ch;
    logic [10:0] addr;
    for (int n = 0; n < count; n++) begin
      while (!steady && $urandom_range(99) < 25) begin
        push <= 1'b0;
        @(posedge clk);
      end
      pick = $urandom_range(99);
      ch   = 8'($urandom_range(255));
      addr = 11'($urandom_range(COLS * ROWS - 1));
      if ($urandom_range(9) == 0) addr = 11'($urandom_range(2047, COLS * ROWS));
      if (pick < 55) begin
        put_request(tcw_pkg::REQ_READ, ch, addr);
      end else begin
        pick = $urandom_range(99);
        if (pick < 12) ch = tcw_pkg::CH_NEWLINE;
        else if (pick < 18) ch = tcw_pkg::CH_TAB;
        put_request(tcw_pkg::REQ_WRITE, ch, addr);
      end
    end
  endtask

  // receiver: random pops, a no-idle window, and a long hold every so often
  initial begin
    pop           = 1'b0;
    results_taken = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        results_taken++;
        if (results_taken % HOLD_EVERY == 0) begin
          pop <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
      end
      pop <= !rst && ((results_taken >= 450 && results_taken < 600) ||
                      $urandom_range(99) >= 25);
    end
  end

  // watchdog: give up after a long stretch with no handshake of any kind
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst          = 1'b1;
    push         = 1'b0;
    req_type     = tcw_pkg::REQ_WRITE;
    char_code    = 8'h00;
    cell_address = 11'd0;
    cfg_valid    = 1'b0;
    cfg_index    = tcw_pkg::CFG_BACKGROUND;
    cfg_data     = 4'h0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // cleared screen, out-of-range reads, odd bytes and both control codes
    put_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
    put_request(tcw_pkg::REQ_READ, 8'h00, 11'd1999);
    put_request(tcw_pkg::REQ_READ, 8'h00, 11'd2000);
    put_request(tcw_pkg::REQ_READ, 8'hFF, 11'd2047);
    put_request(tcw_pkg::REQ_WRITE, 8'h41, 11'd0);
    put_request(tcw_pkg::REQ_WRITE, 8'h00, 11'd0);
    put_request(tcw_pkg::REQ_WRITE, 8'hFF, 11'd2047);
    put_request(tcw_pkg::REQ_WRITE, tcw_pkg::CH_TAB, 11'd0);
    put_request(tcw_pkg::REQ_WRITE, tcw_pkg::CH_NEWLINE, 11'd0);
    put_request(tcw_pkg::REQ_WRITE, tcw_pkg::CH_NEWLINE, 11'd0);
    put_request(tcw_pkg::REQ_READ, 8'h00, 11'd0);
    put_request(tcw_pkg::REQ_READ, 8'h00, 11'd1);
    put_request(tcw_pkg::REQ_READ, 8'h00, 11'd2);
    put_request(tcw_pkg::REQ_READ, 8'h00, 11'd3);
    put_request(tcw_pkg::REQ_READ, 8'h00, 11'd6);
    put_request(tcw_pkg::REQ_READ, 8'h00, 11'd7);
    drain_results();

    set_colours(4'hF, 4'h0);
    stream_random(SEGMENT_ITEMS, 1'b0);
    drain_results();
    set_colours(4'h0, 4'h0);
    stream_random(SEGMENT_ITEMS, 1'b1);
    drain_results();
    set_colours(4'hF, 4'hF);
    stream_random(SEGMENT_ITEMS, 1'b0);
    drain_results();
    set_colours(4'($urandom_range(15)), 4'($urandom_range(15)));
    stream_random(SEGMENT_ITEMS, 1'b0);
    drain_results();

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
